// File: design/alist_pkg.sv
// Shared types, constants and codes for the bounded array list.
package alist_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 5;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [2:0] {
    FN_APPEND      = 3'd0,
    FN_INSERT      = 3'd1,
    FN_REMOVE_AT   = 3'd2,
    FN_REMOVE_LAST = 3'd3,
    FN_READ        = 3'd4,
    FN_WRITE       = 3'd5,
    FN_CLEAR       = 3'd6,
    FN_NOP         = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_APPEND,
    ACT_INSERT0,
    ACT_INSERT,
    ACT_REMOVE,
    ACT_READ,
    ACT_WRITE
  } act_t;

  typedef struct packed {
    act_t              act;
    status_t           status;
    logic [CNT_W-1:0]  new_count;
  } decision_t;

endpackage

// File: design/alist_ram.sv
// Generic single-write, single-read RAM with registered read data.
module alist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/alist_check.sv
// Request decoder: range, full and empty checks and the count after the request.
module alist_check
  import alist_pkg::*;
(
  input  logic [2:0]        func,
  input  logic [POS_W-1:0]  position,
  input  logic [CNT_W-1:0]  count,
  output decision_t         dec
);

  logic [CMP_W-1:0] n;
  logic [CMP_W-1:0] p;
  logic             is_empty;
  logic             is_full;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] cnt_dec;

  assign n        = CMP_W'(count);
  assign p        = CMP_W'(position);
  assign is_empty = (count == '0);
  assign is_full  = (n >= CMP_W'(CAPACITY));
  assign cnt_inc  = count + CNT_W'(1);
  assign cnt_dec  = count - CNT_W'(1);

  always_comb begin
    dec.act       = ACT_NONE;
    dec.status    = ST_OK;
    dec.new_count = count;
    unique case (func_t'(func))
      FN_APPEND: begin
        if (is_full) begin
          dec.status = ST_FULL;
        end else begin
          dec.act       = ACT_APPEND;
          dec.new_count = cnt_inc;
        end
      end
      FN_INSERT: begin
        // An empty list takes the value at the head whatever the index.
        if (is_empty) begin
          dec.act       = ACT_INSERT0;
          dec.new_count = CNT_W'(1);
        end else if (p > n) begin
          dec.status = ST_RANGE;
        end else if (is_full) begin
          dec.status = ST_FULL;
        end else begin
          dec.act       = ACT_INSERT;
          dec.new_count = cnt_inc;
        end
      end
      FN_REMOVE_AT: begin
        if (is_empty) begin
          dec.status = ST_EMPTY;
        end else if (p >= n) begin
          dec.status = ST_RANGE;
        end else begin
          dec.act       = ACT_REMOVE;
          dec.new_count = cnt_dec;
        end
      end
      FN_REMOVE_LAST: begin
        if (is_empty) begin
          dec.status = ST_EMPTY;
        end else begin
          dec.new_count = cnt_dec;
        end
      end
      FN_READ: begin
        if (p >= n) begin
          dec.status = ST_RANGE;
        end else begin
          dec.act = ACT_READ;
        end
      end
      FN_WRITE: begin
        if (p >= n) begin
          dec.status = ST_RANGE;
        end else begin
          dec.act = ACT_WRITE;
        end
      end
      FN_CLEAR: begin
        dec.new_count = '0;
      end
      FN_NOP: begin
        dec.act = ACT_NONE;
      end
      default: begin
        dec.act = ACT_NONE;
      end
    endcase
  end

endmodule

// File: design/array_list_insert_remove.sv
// Bounded ordered list of signed words with insert and remove that shift elements.
// Append, remove last, write, clear and failed requests: result strobe in the cycle after start.
// Read: passes through S_READ. Insert and remove take a read and a write state per moved element.
// Shift moves one element at a time, a read then a write, via the single read and write port.
// busy is high while a shift or read is in flight; the receiver cannot stall, so results never wait.
// Synchronous active-low reset empties the list; the element store itself is not cleared.
module array_list_insert_remove
  import alist_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               in_func,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_item_value,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic [1:0]               out_status,
  output logic [CNT_W-1:0]         out_element_total,
  output logic                     out_list_empty
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_REM_RD,
    S_REM_WR,
    S_READ
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  old_n_r;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [ADDR_W-1:0] pos_r;
  logic [DATA_W-1:0] val_r;
  logic              fin;
  logic              accept;
  decision_t         dec;

  // Store port signals.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  alist_check u_check (
    .func     (in_func),
    .position (in_position),
    .count    (count_r),
    .dec      (dec)
  );

  alist_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Sequencer: each shift step reads one neighbor, then writes it one place over.
  // An insert walks down from the old end to the insert point, a removal walks up.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    fin       = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = val_r;
    ram_raddr = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (dec.act)
            ACT_APPEND: begin
              ram_we    = 1'b1;
              ram_waddr = ADDR_W'(count_r);
              ram_wdata = in_item_value;
              fin       = 1'b1;
            end
            ACT_INSERT0: begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = in_item_value;
              fin       = 1'b1;
            end
            ACT_WRITE: begin
              ram_we    = 1'b1;
              ram_waddr = ADDR_W'(in_position);
              ram_wdata = in_item_value;
              fin       = 1'b1;
            end
            ACT_READ: begin
              ram_raddr = ADDR_W'(in_position);
              state_nxt = S_READ;
            end
            ACT_INSERT: begin
              idx_nxt   = ADDR_W'(count_r);
              state_nxt = S_INS_RD;
            end
            ACT_REMOVE: begin
              idx_nxt   = ADDR_W'(in_position);
              state_nxt = S_REM_RD;
            end
            ACT_NONE: begin
              fin = 1'b1;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_INS_RD: begin
        if (idx_r == pos_r) begin
          // Room has been made: drop the new value into place.
          ram_we    = 1'b1;
          ram_waddr = pos_r;
          ram_wdata = val_r;
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ram_raddr = idx_r - ADDR_W'(1);
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = ram_rdata;
        idx_nxt   = idx_r - ADDR_W'(1);
        state_nxt = S_INS_RD;
      end
      S_REM_RD: begin
        if ((CNT_W'(idx_r) + CNT_W'(1)) >= old_n_r) begin
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ram_raddr = idx_r + ADDR_W'(1);
          state_nxt = S_REM_WR;
        end
      end
      S_REM_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = ram_rdata;
        idx_nxt   = idx_r + ADDR_W'(1);
        state_nxt = S_REM_RD;
      end
      S_READ: begin
        fin       = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, count and result word. The status and count of the word are fixed at
  // accept time; the strobe follows once the store work is done.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= fin;
      if (accept) begin
        count_r <= dec.new_count;
      end
    end
    idx_r <= idx_nxt;
    if (accept) begin
      old_n_r           <= count_r;
      pos_r             <= ADDR_W'(in_position);
      val_r             <= in_item_value;
      out_status        <= dec.status;
      out_element_total <= dec.new_count;
      out_list_empty    <= (dec.new_count == '0);
      out_read_value    <= '0;
    end
    if (state_r == S_READ) begin
      out_read_value <= ram_rdata;
    end
  end

endmodule
